@@ rtl/core/gtc_pkg.sv @@
// Shared types, widths and fixed-point constants for the gyro temperature compensation block.
// The polynomial coefficients are Q48 and the scales are Q32, all worked out at elaboration.
// No dependencies.
package gtc_pkg;

    localparam int AXES    = 3;
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 32;
    localparam int JUMP_W  = 31;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_BIAS_X     = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_Y     = 2'd1;
    localparam logic [IDX_W-1:0] REG_BIAS_Z     = 2'd2;
    localparam logic [IDX_W-1:0] REG_JUMP_LIMIT = 2'd3;

    localparam logic [JUMP_W-1:0] JUMP_RESET = 31'd32768;

    // Lane datapath widths.
    localparam int U_W      = 17;
    localparam int COEF1_W  = 40;
    localparam int COEF2_W  = 28;
    localparam int SCALE_W  = 24;
    localparam int DIFF_W   = 42;
    localparam int OFF24_W  = 40;
    localparam int PROD_W   = 68;
    localparam int R16_W    = 28;
    localparam int LANE_LAT = 7;
    localparam int U_OFFSET = 25000;

    typedef logic signed [RATE_W-1:0] rate_t;

    localparam longint unsigned X_C0_U =
        ((64'd73788764 / 64'd3125) << 43) +
        (((64'd73788764 % 64'd3125) << 43) + 64'd3125 / 2) / 64'd3125;
    localparam longint unsigned X_C1_U =
        ((64'd10979095 / 64'd48828125) << 37) +
        (((64'd10979095 % 64'd48828125) << 37) + 64'd48828125 / 2) / 64'd48828125;
    localparam longint unsigned X_C2_U =
        ((64'd24414819 / 64'd6103515625) << 34) +
        (((64'd24414819 % 64'd6103515625) << 34) + 64'd6103515625 / 2) / 64'd6103515625;
    localparam longint unsigned Y_C0_U =
        ((64'd17459222 / 64'd15625) << 42) +
        (((64'd17459222 % 64'd15625) << 42) + 64'd15625 / 2) / 64'd15625;
    localparam longint unsigned Y_C1_U =
        ((64'd10612476 / 64'd9765625) << 38) +
        (((64'd10612476 % 64'd9765625) << 38) + 64'd9765625 / 2) / 64'd9765625;
    localparam longint unsigned Z_C0_U =
        ((64'd28077884 / 64'd15625) << 42) +
        (((64'd28077884 % 64'd15625) << 42) + 64'd15625 / 2) / 64'd15625;
    localparam longint unsigned Z_C1_U =
        ((64'd14576032 / 64'd48828125) << 37) +
        (((64'd14576032 % 64'd48828125) << 37) + 64'd48828125 / 2) / 64'd48828125;

    localparam longint unsigned SCALE_NUM = (64'd1 << 32) * 64'd1000000000;
    localparam longint unsigned X_SC_U =
        (SCALE_NUM + (64'd82362683 * 64'd9849) / 2) / (64'd82362683 * 64'd9849);
    localparam longint unsigned Y_SC_U =
        (SCALE_NUM + (64'd82362683 * 64'd10107) / 2) / (64'd82362683 * 64'd10107);
    localparam longint unsigned Z_SC_U =
        (SCALE_NUM + (64'd82362683 * 64'd9993) / 2) / (64'd82362683 * 64'd9993);

    localparam logic signed [63:0] C0_TAB [AXES] = '{X_C0_U, Y_C0_U, Z_C0_U};
    localparam logic signed [COEF1_W-1:0] C1_TAB [AXES] =
        '{COEF1_W'(X_C1_U), COEF1_W'(Y_C1_U), COEF1_W'(Z_C1_U)};
    localparam logic signed [COEF2_W-1:0] C2_TAB [AXES] =
        '{COEF2_W'(X_C2_U), COEF2_W'(0), COEF2_W'(0)};
    localparam logic [SCALE_W-1:0] SCALE_TAB [AXES] =
        '{SCALE_W'(X_SC_U), SCALE_W'(Y_SC_U), SCALE_W'(Z_SC_U)};

    // Temperature conversion: floor(N / 280) is done as floor(floor(N / 8) / 35).
    localparam int TV_W      = 17;
    localparam int TM_W      = TV_W + 13;
    localparam int TP_W      = 2 * TM_W;
    localparam int RECIP_SH  = 35;
    localparam int TQ_W      = TP_W - RECIP_SH;
    localparam int TREM_W    = 7;
    localparam int TEMP_BIAS = 32800;
    localparam int TEMP_RND  = 17;
    localparam int TEMP_DIV  = 35;
    localparam int TEMP_OFF  = 35 * 65536;
    localparam logic [TM_W-1:0] TEMP_RECIP = TM_W'((64'd1 << RECIP_SH) / TEMP_DIV);

endpackage

@@ rtl/core/gyro_temp_comp_calibrator.sv @@
// Gyro temperature compensation with plausibility check: top level.
// Instantiates three axis lanes, the temperature unit and the merging stage.
// Depends on gtc_pkg, gtc_axis_lane, gtc_temp_unit and gtc_merge.
//
// An input item (raw_x, raw_y, raw_z, raw_temp) is taken when in_valid and in_ready
// are both high. The three axis lanes and the temperature unit work on it side by
// side; the axis lanes with their seven register stages are the longer path, so the
// result is loaded into the output register once the lanes are done and it is free.
// One item is in flight at a time and in_ready rises only in the cycle after the
// load, so the block takes no new item before the last one is loaded.
// A result waits in the output register with out_valid high until out_ready is
// high. While it waits, the next item is taken and worked on; if the receiver still
// stalls when that item is finished, it is held in the lanes and in_ready stays low.
// Registers are written via cfg_we, cfg_index and cfg_data only with no item in
// flight; the block does not enforce this, the user must. Reset clears the biases,
// the last accepted rates, out_valid and sequencer, and sets the jump limit to 0.5.
module gyro_temp_comp_calibrator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [gtc_pkg::RAW_W-1:0]   raw_x,
    input  logic signed [gtc_pkg::RAW_W-1:0]   raw_y,
    input  logic signed [gtc_pkg::RAW_W-1:0]   raw_z,
    input  logic signed [gtc_pkg::RAW_W-1:0]   raw_temp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gtc_pkg::RATE_W-1:0]  rate_x,
    output logic signed [gtc_pkg::RATE_W-1:0]  rate_y,
    output logic signed [gtc_pkg::RATE_W-1:0]  rate_z,
    output logic signed [gtc_pkg::RATE_W-1:0]  temp_c,
    output logic                               plausible,
    input  logic                               cfg_we,
    input  logic [gtc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gtc_pkg::RATE_W-1:0]         cfg_data
);
    import gtc_pkg::*;

    localparam int CNT_W = $clog2(LANE_LAT + 1);

    logic signed [RAW_W-1:0] raw_reg [AXES];
    logic signed [RAW_W-1:0] temp_raw_reg;
    rate_t                   bias_reg [AXES];
    logic [JUMP_W-1:0]       jump_limit_reg;
    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    accept;
    logic                    done;
    logic                    load;
    rate_t                   lane_rate [AXES];
    rate_t                   lane_temp;
    rate_t                   res_rate [AXES];
    rate_t                   res_temp;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign done     = busy_reg && cnt_reg == CNT_W'(LANE_LAT);
    assign load     = done && (!out_valid_reg || out_ready);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (load)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !done)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0]   <= raw_x;
            raw_reg[1]   <= raw_y;
            raw_reg[2]   <= raw_z;
            temp_raw_reg <= raw_temp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                bias_reg[i] <= '0;
            end
            jump_limit_reg <= JUMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIAS_X:     bias_reg[0]    <= cfg_data;
                REG_BIAS_Y:     bias_reg[1]    <= cfg_data;
                REG_BIAS_Z:     bias_reg[2]    <= cfg_data;
                REG_JUMP_LIMIT: jump_limit_reg <= cfg_data[JUMP_W-1:0];
                default:        jump_limit_reg <= jump_limit_reg;
            endcase
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        gtc_axis_lane #(
            .AXIS (g)
        ) u_lane (
            .clk      (clk),
            .raw      (raw_reg[g]),
            .temp_raw (temp_raw_reg),
            .bias     (bias_reg[g]),
            .rate     (lane_rate[g])
        );
    end

    gtc_temp_unit u_temp (
        .clk      (clk),
        .temp_raw (temp_raw_reg),
        .temp_c   (lane_temp)
    );

    gtc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .rates      (lane_rate),
        .temp_in    (lane_temp),
        .jump_limit (jump_limit_reg),
        .rates_out  (res_rate),
        .temp_out   (res_temp),
        .plausible  (plausible)
    );

    assign out_valid = out_valid_reg;
    assign rate_x    = res_rate[0];
    assign rate_y    = res_rate[1];
    assign rate_z    = res_rate[2];
    assign temp_c    = res_temp;

    a_start : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && cnt_reg == '0)
        else $error("sequencer did not start on a taken item");

    a_count : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !done |=> busy_reg && cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("sequencer skipped a step");

    a_load : assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && !busy_reg)
        else $error("result load did not set valid and free the lanes");

endmodule

@@ rtl/core/gtc_axis_lane.sv @@
// One axis lane: temperature polynomial offset, scale multiply, bias and saturation.
// Seven register stages; inputs must stay stable while an item is in flight.
// Depends on gtc_pkg.
module gtc_axis_lane #(
    parameter int AXIS = 0
) (
    input  logic                               clk,
    input  logic signed [gtc_pkg::RAW_W-1:0]   raw,
    input  logic signed [gtc_pkg::RAW_W-1:0]   temp_raw,
    input  gtc_pkg::rate_t                     bias,
    output gtc_pkg::rate_t                     rate
);
    import gtc_pkg::*;

    localparam logic signed [63:0]         C0    = C0_TAB[AXIS];
    localparam logic signed [COEF1_W-1:0]  C1    = C1_TAB[AXIS];
    localparam logic signed [COEF2_W-1:0]  C2    = C2_TAB[AXIS];
    localparam logic [SCALE_W-1:0]         SCALE = SCALE_TAB[AXIS];
    localparam logic signed [63:0]         OFF_HALF  = 64'sd1 <<< 23;
    localparam logic signed [PROD_W-1:0]   PROD_HALF = PROD_W'(64'd1 << 39);
    localparam int SAT_W = RATE_W + 2;

    logic signed [U_W-1:0]                u;
    logic signed [2*U_W-1:0]              usq_reg;
    logic signed [COEF1_W+U_W-1:0]        lin_reg;
    logic signed [COEF2_W+2*U_W-1:0]      quad_reg;
    logic signed [63:0]                   off48_reg;
    logic signed [63:0]                   off_rnd;
    logic signed [DIFF_W-1:0]             raw_sh;
    logic signed [DIFF_W-1:0]             diff_reg;
    logic [2*SCALE_W-1:0]                 lo_reg;
    logic signed [DIFF_W-SCALE_W+SCALE_W:0] hi_reg;
    logic signed [PROD_W-1:0]             hi_ext;
    logic signed [PROD_W-1:0]             lo_ext;
    logic signed [PROD_W-1:0]             prod_sum;
    logic signed [R16_W-1:0]              r16_reg;
    logic signed [SAT_W-1:0]              wide;
    rate_t                                rate_reg;

    assign u = {temp_raw[RAW_W-1], temp_raw} + U_W'(U_OFFSET);
    assign off_rnd = off48_reg + OFF_HALF;
    assign raw_sh = {{(DIFF_W-RAW_W-24){raw[RAW_W-1]}}, raw, 24'd0};
    assign hi_ext = PROD_W'(hi_reg);
    assign lo_ext = $signed(PROD_W'(lo_reg));
    assign prod_sum = (hi_ext <<< 24) + lo_ext + PROD_HALF;
    assign wide = SAT_W'(r16_reg) - SAT_W'(bias);

    always_ff @(posedge clk)
    begin
        usq_reg   <= u * u;
        lin_reg   <= C1 * u;
        quad_reg  <= C2 * usq_reg;
        off48_reg <= C0 - 64'(lin_reg) - 64'(quad_reg);
        diff_reg  <= raw_sh - DIFF_W'($signed(off_rnd[63:24]));
        lo_reg    <= diff_reg[SCALE_W-1:0] * SCALE;
        hi_reg    <= $signed(diff_reg[DIFF_W-1:SCALE_W]) * $signed({1'b0, SCALE});
        r16_reg   <= prod_sum[PROD_W-1:40];
        if (wide[SAT_W-1:RATE_W-1] == '0 || wide[SAT_W-1:RATE_W-1] == '1)
        begin
            rate_reg <= wide[RATE_W-1:0];
        end
        else if (wide[SAT_W-1])
        begin
            rate_reg <= {1'b1, {(RATE_W-1){1'b0}}};
        end
        else
        begin
            rate_reg <= {1'b0, {(RATE_W-1){1'b1}}};
        end
    end

    assign rate = rate_reg;

endmodule

@@ rtl/core/gtc_temp_unit.sv @@
// Temperature conversion to degrees C in Q16.16 by reciprocal multiply and one correction.
// Four register stages; the input must stay stable while an item is in flight.
// Depends on gtc_pkg.
module gtc_temp_unit (
    input  logic                               clk,
    input  logic signed [gtc_pkg::RAW_W-1:0]   temp_raw,
    output gtc_pkg::rate_t                     temp_c
);
    import gtc_pkg::*;

    logic [TV_W-1:0]    v;
    logic [TM_W-1:0]    m_reg;
    logic [TP_W-1:0]    prod_reg;
    logic [TQ_W-1:0]    q0;
    logic [TM_W-1:0]    rem;
    logic [TQ_W-1:0]    q0_reg;
    logic [TREM_W-1:0]  rem_reg;
    rate_t              temp_reg;

    assign v   = {temp_raw[RAW_W-1], temp_raw} + TV_W'(TEMP_BIAS);
    assign q0  = prod_reg[TP_W-1:RECIP_SH];
    assign rem = m_reg - TM_W'(TM_W'(q0) * TM_W'(TEMP_DIV));

    always_ff @(posedge clk)
    begin
        m_reg    <= {v, 13'd0} + TM_W'(TEMP_RND);
        prod_reg <= m_reg * TEMP_RECIP;
        q0_reg   <= q0;
        rem_reg  <= rem[TREM_W-1:0];
        temp_reg <= RATE_W'(q0_reg) + RATE_W'(rem_reg >= TREM_W'(TEMP_DIV))
                    - RATE_W'(TEMP_OFF);
    end

    assign temp_c = temp_reg;

endmodule

@@ rtl/core/gtc_merge.sv @@
// Merging stage: jump test of all lanes against the last accepted rates, result register.
// The last accepted rates are replaced only when every axis passes.
// Depends on gtc_pkg.
module gtc_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  gtc_pkg::rate_t            rates [gtc_pkg::AXES],
    input  gtc_pkg::rate_t            temp_in,
    input  logic [gtc_pkg::JUMP_W-1:0] jump_limit,
    output gtc_pkg::rate_t            rates_out [gtc_pkg::AXES],
    output gtc_pkg::rate_t            temp_out,
    output logic                      plausible
);
    import gtc_pkg::*;

    localparam int D_W = RATE_W + 1;

    rate_t             last_rate_reg [AXES];
    rate_t             rates_out_reg [AXES];
    rate_t             temp_out_reg;
    logic              plausible_reg;
    logic [AXES-1:0]   fail;
    logic              ok;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic signed [D_W-1:0] delta;
            logic [D_W-1:0] mag;
            delta = D_W'(last_rate_reg[i]) - D_W'(rates[i]);
            mag = delta[D_W-1] ? D_W'(-delta) : D_W'(delta);
            fail[i] = mag > D_W'(jump_limit);
        end
    end

    assign ok = ~|fail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                last_rate_reg[i] <= '0;
            end
        end
        else if (load && ok)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                last_rate_reg[i] <= rates[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rates_out_reg <= rates;
            temp_out_reg  <= temp_in;
            plausible_reg <= ok;
        end
    end

    assign rates_out = rates_out_reg;
    assign temp_out  = temp_out_reg;
    assign plausible = plausible_reg;

    a_keep_last : assert property (@(posedge clk) disable iff (!rst_n)
        load && !ok |=> $stable(last_rate_reg[0]) && $stable(last_rate_reg[1])
                        && $stable(last_rate_reg[2]))
        else $error("last rates changed after an implausible item");

    a_take_last : assert property (@(posedge clk) disable iff (!rst_n)
        load && ok |=> last_rate_reg[0] == rates_out_reg[0]
                       && last_rate_reg[1] == rates_out_reg[1]
                       && last_rate_reg[2] == rates_out_reg[2] && plausible_reg)
        else $error("last rates do not match a plausible result");

    a_hold_last : assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(last_rate_reg[0]) && $stable(last_rate_reg[1])
                  && $stable(last_rate_reg[2]))
        else $error("last rates changed without a result load");

endmodule
